### sv/dfp_pkg.sv
// Shared constants and types for the disk command file name parser.
`default_nettype none
package dfp_pkg;

  // Characters recognized in the command string
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_S      = 8'h53;
  localparam logic [7:0] CH_P      = 8'h50;
  localparam logic [7:0] CH_U      = 8'h55;
  localparam logic [7:0] CH_L      = 8'h4C;
  localparam logic [7:0] CH_R      = 8'h52;
  localparam logic [7:0] CH_W      = 8'h57;

  // Largest legal record size; anything above it overflows
  localparam logic [7:0] REC_MAX = 8'd254;

  // At most this many name bytes are emitted and counted
  localparam logic [5:0] NAME_OUT_MAX = 6'd32;

  // File kind codes
  localparam logic [2:0] KIND_UNSET = 3'd0;
  localparam logic [2:0] KIND_SEQ   = 3'd1;
  localparam logic [2:0] KIND_PRG   = 3'd2;
  localparam logic [2:0] KIND_USR   = 3'd3;
  localparam logic [2:0] KIND_REL   = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Secondary addresses with special meaning
  localparam logic [3:0] SA_READ  = 4'd0;
  localparam logic [3:0] SA_WRITE = 4'd1;

  // Parse start request from the loader
  typedef struct packed {
    logic       go;
    logic [3:0] sa;
  } start_t;

  // Result item as carried on the output stream
  typedef struct packed {
    logic [7:0] name_char;
    logic       char_valid;
    logic       end_of_run;
    logic [5:0] name_length;
    logic [2:0] file_kind;
    logic       write_mode;
    logic [7:0] record_size;
    logic [1:0] status;
  } result_t;

endpackage
`default_nettype wire

### sv/disk_command_filename_parser.sv
// Top level: command loader, command store and parse sequencer.
// Loading takes one command byte per cycle while idle; the final byte starts the parse.
// Parsing reads the store through its one registered read port, a read state
// and then an evaluate state per byte walked; an output stall holds the walk.
// Input is not taken while a parse runs; the last result may still be waiting.
// Reset (rst, synchronous) clears control, fill count and held record size;
// the command store is not cleared.
`default_nettype none
module disk_command_filename_parser #(
  parameter int MAX_CMD_LEN = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // tdata: cmd_byte[7:0], secondary_address[11:8], zero fill [15:12]
  input  wire logic [15:0] s_tdata,
  input  wire logic        s_tlast,   // final_byte
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // tdata: name_char[7:0], name_length[13:8], file_kind[16:14], write_mode[17],
  //        record_size[25:18], status[27:26], zero fill [31:28]
  output logic [31:0]      m_tdata,
  output logic             m_tuser,   // char_valid
  output logic             m_tlast,   // end_of_run
  output logic             m_tvalid,
  input  wire logic        m_tready
);

  localparam int AW = $clog2(MAX_CMD_LEN);
  localparam int CW = $clog2(MAX_CMD_LEN + 1);
  localparam logic [CW-1:0] MAX_FILL = CW'(MAX_CMD_LEN);

  logic [CW-1:0]     fill_count;
  logic              accept;
  logic              room;
  logic [CW-1:0]     n_in;
  dfp_pkg::start_t   start;
  logic              busy;
  logic [AW-1:0]     raddr;
  logic [7:0]        rdata;
  dfp_pkg::result_t  item;

  assign s_tready = !busy;
  assign accept   = s_tvalid && s_tready;
  assign room     = (fill_count < MAX_FILL);
  assign n_in     = room ? fill_count + 1'b1 : fill_count;

  assign start.go = accept && s_tlast;
  assign start.sa = s_tdata[11:8];

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        fill_count <= '0;
      end else if (room) begin
        fill_count <= fill_count + 1'b1;
      end
    end
  end

  dfp_store #(
    .DEPTH (MAX_CMD_LEN),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (accept && room),
    .waddr (fill_count[AW-1:0]),
    .wdata (s_tdata[7:0]),
    .raddr (raddr),
    .rdata (rdata)
  );

  dfp_parser #(
    .AW (AW),
    .CW (CW)
  ) u_parser (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .n_in      (n_in),
    .busy      (busy),
    .raddr     (raddr),
    .rdata     (rdata),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_item  (item)
  );

  assign m_tdata = {4'd0, item.status, item.record_size, item.write_mode,
                    item.file_kind, item.name_length, item.name_char};
  assign m_tuser = item.char_valid;
  assign m_tlast = item.end_of_run;

endmodule
`default_nettype wire

### sv/dfp_store.sv
// Command byte store: one write port, one registered read port.
`default_nettype none
module dfp_store #(
  parameter int DEPTH = 32,
  parameter int AW    = 5
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic [AW-1:0] raddr,
  output logic [7:0]         rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### sv/dfp_parser.sv
// Parse sequencer: walks the stored command and drives the result register.
`default_nettype none
module dfp_parser #(
  parameter int AW = 5,
  parameter int CW = 6
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire dfp_pkg::start_t start,
  input  wire logic [CW-1:0]   n_in,
  output logic                 busy,
  output logic [AW-1:0]        raddr,
  input  wire logic [7:0]      rdata,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output dfp_pkg::result_t     out_item
);

  localparam int PW = CW + 1;

  typedef enum logic [3:0] {
    S_IDLE, S_COLON_RD, S_COLON_EV, S_NAME_RD, S_NAME_EV, S_OPT_RD, S_OPT_EV,
    S_L1_RD, S_L1_EV, S_L2_RD, S_L2_EV, S_COMMA_RD, S_COMMA_EV, S_SUMMARY
  } state_t;

  state_t        state;
  logic [PW-1:0] addr;
  logic [PW-1:0] n;
  logic [3:0]    sa;
  logic [2:0]    kind;
  logic          mode;
  logic [1:0]    status;
  logic [5:0]    cnt;
  logic          dollar;
  logic [7:0]    held_rec;

  logic          at_end;
  logic          out_free;
  logic [2:0]    fin_kind;
  logic          fin_mode;

  assign raddr    = addr[AW-1:0];
  assign busy     = (state != S_IDLE);
  assign at_end   = (addr >= n);
  assign out_free = !out_valid || out_ready;

  // Completed parse with OK status: secondary address override and default kind
  always_comb begin
    fin_kind = kind;
    fin_mode = mode;
    if (status == dfp_pkg::ST_OK) begin
      if (sa == dfp_pkg::SA_READ) begin
        fin_mode = 1'b0;
      end else if (sa == dfp_pkg::SA_WRITE) begin
        fin_mode = 1'b1;
      end
      if (kind == dfp_pkg::KIND_UNSET) begin
        fin_kind = (sa < 4'd2) ? dfp_pkg::KIND_PRG : dfp_pkg::KIND_SEQ;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      held_rec  <= 8'd0;
      addr      <= '0;
      n         <= '0;
      sa        <= '0;
      kind      <= dfp_pkg::KIND_UNSET;
      mode      <= 1'b0;
      status    <= dfp_pkg::ST_OK;
      cnt       <= '0;
      dollar    <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (start.go) begin
            n      <= {1'b0, n_in};
            sa     <= start.sa;
            mode   <= (start.sa == dfp_pkg::SA_WRITE);
            kind   <= dfp_pkg::KIND_UNSET;
            status <= dfp_pkg::ST_OK;
            cnt    <= '0;
            addr   <= '0;
            dollar <= 1'b0;
            state  <= S_COLON_RD;
          end
        end
        S_COLON_RD: begin
          if (at_end) begin
            // no colon: empty name after a leading '$', else name from start
            addr  <= dollar ? n : '0;
            state <= S_NAME_RD;
          end else begin
            state <= S_COLON_EV;
          end
        end
        S_COLON_EV: begin
          if (addr == '0) begin
            dollar <= (rdata == dfp_pkg::CH_DOLLAR);
          end
          addr  <= addr + 1'b1;
          state <= (rdata == dfp_pkg::CH_COLON) ? S_NAME_RD : S_COLON_RD;
        end
        S_NAME_RD: begin
          state <= at_end ? S_SUMMARY : S_NAME_EV;
        end
        S_NAME_EV: begin
          if (rdata == dfp_pkg::CH_COMMA) begin
            addr  <= addr + 1'b1;
            state <= S_OPT_RD;
          end else if (cnt >= dfp_pkg::NAME_OUT_MAX) begin
            addr  <= addr + 1'b1;
            state <= S_NAME_RD;
          end else if (out_free) begin
            out_valid            <= 1'b1;
            out_item             <= '0;
            out_item.name_char   <= rdata;
            out_item.char_valid  <= 1'b1;
            cnt                  <= cnt + 1'b1;
            addr                 <= addr + 1'b1;
            state                <= S_NAME_RD;
          end
        end
        S_OPT_RD: begin
          if (at_end) begin
            // comma as last byte
            status <= dfp_pkg::ST_INVALID;
            state  <= S_SUMMARY;
          end else begin
            state <= S_OPT_EV;
          end
        end
        S_OPT_EV: begin
          addr  <= addr + 1'b1;
          state <= S_COMMA_RD;
          priority case (rdata)
            dfp_pkg::CH_S: kind <= dfp_pkg::KIND_SEQ;
            dfp_pkg::CH_P: kind <= dfp_pkg::KIND_PRG;
            dfp_pkg::CH_U: kind <= dfp_pkg::KIND_USR;
            dfp_pkg::CH_R: mode <= 1'b0;
            dfp_pkg::CH_W: mode <= 1'b1;
            dfp_pkg::CH_L: state <= S_L1_RD;
            dfp_pkg::CH_COMMA: state <= S_OPT_RD;  // empty option
            default: ;
          endcase
        end
        S_L1_RD: begin
          if (at_end) begin
            kind  <= dfp_pkg::KIND_REL;
            state <= S_COMMA_RD;
          end else begin
            state <= S_L1_EV;
          end
        end
        S_L1_EV: begin
          addr <= addr + 1'b1;
          if (rdata == dfp_pkg::CH_COMMA) begin
            state <= S_L2_RD;
          end else begin
            kind  <= dfp_pkg::KIND_REL;
            state <= S_COMMA_RD;
          end
        end
        S_L2_RD: begin
          if (at_end) begin
            // record byte missing reads as zero; its comma opens an option
            held_rec <= 8'd0;
            kind     <= dfp_pkg::KIND_REL;
            state    <= S_OPT_RD;
          end else begin
            state <= S_L2_EV;
          end
        end
        S_L2_EV: begin
          held_rec <= rdata;
          if (rdata > dfp_pkg::REC_MAX) begin
            status <= dfp_pkg::ST_OVERFLOW;
            state  <= S_SUMMARY;
          end else begin
            // record byte itself is scanned as the next option letter
            kind  <= dfp_pkg::KIND_REL;
            state <= S_OPT_RD;
          end
        end
        S_COMMA_RD: begin
          state <= at_end ? S_SUMMARY : S_COMMA_EV;
        end
        S_COMMA_EV: begin
          addr  <= addr + 1'b1;
          state <= (rdata == dfp_pkg::CH_COMMA) ? S_OPT_RD : S_COMMA_RD;
        end
        S_SUMMARY: begin
          if (out_free) begin
            out_valid            <= 1'b1;
            out_item             <= '0;
            out_item.end_of_run  <= 1'b1;
            out_item.name_length <= cnt;
            out_item.file_kind   <= fin_kind;
            out_item.write_mode  <= fin_mode;
            out_item.record_size <= held_rec;
            out_item.status      <= status;
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire
